// File: rtl/gcr_sync_gap_run_counter_unit_macros.svh
// assertion macros used by the checker file
`ifndef GCR_SYNC_GAP_RUN_COUNTER_UNIT_MACROS_SVH
`define GCR_SYNC_GAP_RUN_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GCR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("gcr check failed");

// next-cycle implication, disabled while in reset
`define GCR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("gcr check failed");

`endif

// File: rtl/gcr_pkg.sv
package gcr_pkg;

    // track geometry
    localparam int TRACK_BYTES = 8192;

    // field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 14;
    localparam int CNT_W  = 13;
    localparam int IDX_W  = 2;
    localparam int DATA_W = LEN_W + 2 * CNT_W;

    // saturation limits
    localparam logic [LEN_W-1:0] RUN_CAP =
        LEN_W'(TRACK_BYTES < 16383 ? TRACK_BYTES : 16383);
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'(TRACK_BYTES / 2 < 8191 ? TRACK_BYTES / 2 : 8191);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SYNC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GAP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SYNC_FILL = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAP_FILL  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LEAD_MASK = 2'd2;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] SYNC_FILL_RST = 8'hff;
    localparam logic [BYTE_W-1:0] GAP_FILL_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] LEAD_MASK_RST = 8'h03;

    // most results one byte can produce
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_fill;
        logic [BYTE_W-1:0] gap_fill;
        logic [BYTE_W-1:0] lead_mask;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  run_length;
        logic [CNT_W-1:0]  sync_total;
        logic [CNT_W-1:0]  gap_total;
        logic              final_res;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] item;
        logic [1:0]            count;
    } res_list_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v < RUN_CAP) ? v + LEN_W'(1) : RUN_CAP;
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        return (v < CNT_CAP) ? v + CNT_W'(1) : CNT_CAP;
    endfunction

    function automatic result_t make_res(
        input logic [KIND_W-1:0] kind,
        input logic [LEN_W-1:0]  len,
        input logic [CNT_W-1:0]  s_tot,
        input logic [CNT_W-1:0]  g_tot,
        input logic              fin
    );
        result_t r;
        r.kind       = kind;
        r.run_length = len;
        r.sync_total = s_tot;
        r.gap_total  = g_tot;
        r.final_res  = fin;
        return r;
    endfunction

endpackage

// File: rtl/gcr_run_detect.sv
module gcr_run_detect (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gcr_pkg::cfg_t                    cfg,
    input  logic                             fire,
    input  logic [gcr_pkg::BYTE_W-1:0]       data_byte,
    input  logic                             end_of_track,
    output gcr_pkg::res_list_t               res
);
    import gcr_pkg::*;

    logic [BYTE_W-1:0] prior_byte_reg, prior_byte_next;
    logic              prior_valid_reg, prior_valid_next;
    logic              in_sync_reg, in_sync_next;
    logic              in_gap_reg, in_gap_next;
    logic [LEN_W-1:0]  sync_run_reg, sync_run_next;
    logic [LEN_W-1:0]  gap_run_reg, gap_run_next;
    logic [CNT_W-1:0]  sync_seen_reg, sync_seen_next;
    logic [CNT_W-1:0]  gap_seen_reg, gap_seen_next;
    logic [1:0]        n;

    // judge the held-back byte with the current byte as lookahead
    always_comb
    begin
        prior_byte_next  = data_byte;
        prior_valid_next = 1'b1;
        in_sync_next     = in_sync_reg;
        in_gap_next      = in_gap_reg;
        sync_run_next    = sync_run_reg;
        gap_run_next     = gap_run_reg;
        sync_seen_next   = sync_seen_reg;
        gap_seen_next    = gap_seen_reg;
        res              = '0;
        n                = 2'd0;

        if (prior_valid_reg)
        begin
            // sync detector
            if (in_sync_reg)
            begin
                if (prior_byte_reg == cfg.sync_fill)
                begin
                    sync_run_next = sat_len(sync_run_reg);
                end
                else
                begin
                    in_sync_next = 1'b0;
                    res.item[n]  = make_res(KIND_SYNC, sync_run_reg, sync_seen_reg,
                                            gap_seen_reg, 1'b0);
                    n             = n + 2'd1;
                    sync_run_next = '0;
                end
            end
            else if (((prior_byte_reg & cfg.lead_mask) == cfg.lead_mask) &&
                     (data_byte == cfg.sync_fill))
            begin
                in_sync_next   = 1'b1;
                sync_seen_next = sat_cnt(sync_seen_reg);
                sync_run_next  = LEN_W'(1);
            end

            // gap detector
            if (in_gap_reg)
            begin
                if (prior_byte_reg == cfg.gap_fill)
                begin
                    gap_run_next = sat_len(gap_run_reg);
                end
                else
                begin
                    in_gap_next = 1'b0;
                    res.item[n] = make_res(KIND_GAP, gap_run_reg, sync_seen_next,
                                           gap_seen_reg, 1'b0);
                    n            = n + 2'd1;
                    gap_run_next = '0;
                end
            end
            else if ((prior_byte_reg == cfg.gap_fill) && (data_byte == cfg.gap_fill))
            begin
                in_gap_next   = 1'b1;
                gap_seen_next = sat_cnt(gap_seen_reg);
                gap_run_next  = LEN_W'(1);
            end
        end

        // end of track: flush open runs, summary, then clear the track
        if (end_of_track)
        begin
            if (in_sync_next)
            begin
                res.item[n] = make_res(KIND_SYNC, sync_run_next, sync_seen_next,
                                       gap_seen_next, 1'b0);
                n = n + 2'd1;
            end
            if (in_gap_next)
            begin
                res.item[n] = make_res(KIND_GAP, gap_run_next, sync_seen_next,
                                       gap_seen_next, 1'b0);
                n = n + 2'd1;
            end
            res.item[n] = make_res(KIND_SUMMARY, '0, sync_seen_next, gap_seen_next, 1'b1);
            n = n + 2'd1;

            prior_byte_next  = '0;
            prior_valid_next = 1'b0;
            in_sync_next     = 1'b0;
            in_gap_next      = 1'b0;
            sync_run_next    = '0;
            gap_run_next     = '0;
            sync_seen_next   = '0;
            gap_seen_next    = '0;
        end

        res.count = n;
    end

    // track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_byte_reg  <= '0;
            prior_valid_reg <= 1'b0;
            in_sync_reg     <= 1'b0;
            in_gap_reg      <= 1'b0;
            sync_run_reg    <= '0;
            gap_run_reg     <= '0;
            sync_seen_reg   <= '0;
            gap_seen_reg    <= '0;
        end
        else if (fire)
        begin
            prior_byte_reg  <= prior_byte_next;
            prior_valid_reg <= prior_valid_next;
            in_sync_reg     <= in_sync_next;
            in_gap_reg      <= in_gap_next;
            sync_run_reg    <= sync_run_next;
            gap_run_reg     <= gap_run_next;
            sync_seen_reg   <= sync_seen_next;
            gap_seen_reg    <= gap_seen_next;
        end
    end

endmodule

// File: rtl/gcr_result_queue.sv
module gcr_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  gcr_pkg::res_list_t res,
    output logic               load_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output gcr_pkg::result_t   out_res
);
    import gcr_pkg::*;

    result_t [MAX_RES-1:0] q_reg;
    logic [1:0]            cnt_reg;
    logic                  pop;

    // head of the queue drives the output
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = q_reg[0];
    assign pop       = out_valid && out_ready;

    // room for a fresh list once the last pending result leaves
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= res.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // payload: load a new list or shift down on each transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= res.item;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

endmodule

// File: rtl/gcr_sync_gap_run_counter_unit.sv
// a byte passes the input register, then its results load the result queue
// throughput: one byte per cycle while m_axis_tready stays high and each byte
// yields at most one result; a byte yielding more (up to three) holds the slave
// side while they drain through the head register of the three-entry result queue
// reset: asynchronous, active low; clears track state, queue and config to defaults
module gcr_sync_gap_run_counter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gcr_pkg::IDX_W-1:0]      cfg_index,
    input  logic [gcr_pkg::BYTE_W-1:0]     cfg_data,
    // byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tlast,   // end_of_track
    // run reports out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,   // [13:0] run_length,
                                                           // [26:14] sync_total,
                                                           // [39:27] gap_total
    output logic [1:0]                     m_axis_tuser,   // [1:0] kind
    output logic                           m_axis_tlast    // final_res
);
    import gcr_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eot_reg;
    logic              load_ok;
    logic              fire;
    res_list_t         res;
    result_t           out_res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_fill <= SYNC_FILL_RST;
            cfg_reg.gap_fill  <= GAP_FILL_RST;
            cfg_reg.lead_mask <= LEAD_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SYNC_FILL: cfg_reg.sync_fill <= cfg_data;
                REG_GAP_FILL:  cfg_reg.gap_fill  <= cfg_data;
                REG_LEAD_MASK: cfg_reg.lead_mask <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register
    assign fire          = in_valid_reg && load_ok;
    assign s_axis_tready = !in_valid_reg || load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            in_eot_reg  <= s_axis_tlast;
        end
    end

    // run detectors
    gcr_run_detect u_detect (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (fire),
        .data_byte    (in_byte_reg),
        .end_of_track (in_eot_reg),
        .res          (res)
    );

    // result queue
    gcr_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // pack the result transaction
    assign m_axis_tdata = {out_res.gap_total, out_res.sync_total, out_res.run_length};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.final_res;

endmodule

// File: rtl/gcr_checker.sv
`include "gcr_sync_gap_run_counter_unit_macros.svh"

module gcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import gcr_pkg::*;

    logic        out_stall;
    logic [42:0] out_word;
    logic        kind_ok;
    logic        is_summary;
    logic        len_zero;

    // views of the result channel
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign kind_ok    = (m_axis_tuser == KIND_SYNC) || (m_axis_tuser == KIND_GAP) ||
                        (m_axis_tuser == KIND_SUMMARY);
    assign is_summary = (m_axis_tuser == KIND_SUMMARY);
    assign len_zero   = (m_axis_tdata[LEN_W-1:0] == '0);

    // a stalled result transaction keeps its payload
    `GCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // only defined kinds leave the block
    `GCR_ASSERT_NOW(a_kind_ok, clk, rst_n, m_axis_tvalid, kind_ok)

    // final flag marks exactly the summary
    `GCR_ASSERT_NOW(a_last_is_summary, clk, rst_n, m_axis_tvalid, m_axis_tlast == is_summary)

    // run reports carry a nonzero length, the summary none
    `GCR_ASSERT_NOW(a_len_ok, clk, rst_n, m_axis_tvalid, len_zero == m_axis_tlast)

endmodule

bind gcr_sync_gap_run_counter_unit gcr_checker u_gcr_checker (.*);
